### design/bsig_pkg.sv
package bsig_pkg;

  localparam int IDX_W      = 24;
  localparam int EXT_W      = 9;
  localparam int NUMD_W     = 2;
  localparam int NUM_REGS   = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int IN_TDATA_W = 8;

  localparam int DEF_MAX_DIMS   = 3;
  localparam int DEF_MAX_EXTENT = 256;

  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_DIMS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_EXTENT_0 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_EXTENT_1 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_EXTENT_2 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TILE_0   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_TILE_1   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_TILE_2   = 3'd6;

  typedef struct packed {
    logic div_load;
    logic div_step;
    logic div_store;
    logic clear_coords;
    logic advance;
    logic stride_init;
    logic stride_step;
    logic acc_clear;
    logic set_bad;
    logic pos_load;
    logic mac;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic shape_ok;
  } sts_t;

endpackage

### design/bsig_ctrl.sv
module bsig_ctrl #(
  parameter int MAX_DIMS = bsig_pkg::DEF_MAX_DIMS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_restart,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wr_en,
  input  bsig_pkg::sts_t        sts,
  input  logic [$clog2(((MAX_DIMS < bsig_pkg::NUM_REGS) ? MAX_DIMS
                        : bsig_pkg::NUM_REGS) + 1)-1:0] n_dims,
  output bsig_pkg::cmd_t        cmd,
  output logic [((((MAX_DIMS < bsig_pkg::NUM_REGS) ? MAX_DIMS
                  : bsig_pkg::NUM_REGS) > 1) ? $clog2((MAX_DIMS < bsig_pkg::NUM_REGS)
                  ? MAX_DIMS : bsig_pkg::NUM_REGS) : 1)-1:0] dim
);
  import bsig_pkg::*;

  localparam int ND     = (MAX_DIMS < NUM_REGS) ? MAX_DIMS : NUM_REGS;
  localparam int NW     = $clog2(ND + 1);
  localparam int DW     = (ND > 1) ? $clog2(ND) : 1;
  localparam int STEP_W = $clog2(EXT_W);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DIV_LOAD  = 4'd1;
  localparam logic [3:0] S_DIV_STEP  = 4'd2;
  localparam logic [3:0] S_DIV_STORE = 4'd3;
  localparam logic [3:0] S_CHECK     = 4'd4;
  localparam logic [3:0] S_STRIDE    = 4'd5;
  localparam logic [3:0] S_POS       = 4'd6;
  localparam logic [3:0] S_MAC       = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [DW-1:0]     dim_r, dim_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              dirty_r, dirty_nxt;
  logic              started_r, started_nxt;
  logic              restart_r, restart_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign dim        = dim_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    dim_nxt       = dim_r;
    step_nxt      = step_r;
    dirty_nxt     = dirty_r;
    started_nxt   = started_r;
    restart_nxt   = restart_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          restart_nxt = in_restart;
          if (dirty_r) begin
            dim_nxt   = '0;
            state_nxt = S_DIV_LOAD;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(EXT_W - 1)) begin
          state_nxt = S_DIV_STORE;
        end
      end
      S_DIV_STORE: begin
        cmd.div_store = 1'b1;
        if (32'(dim_r) == ND - 1) begin
          dirty_nxt = 1'b0;
          state_nxt = S_CHECK;
        end else begin
          dim_nxt   = dim_r + DW'(1);
          state_nxt = S_DIV_LOAD;
        end
      end
      S_CHECK: begin
        cmd.acc_clear = 1'b1;
        if (!sts.shape_ok) begin
          cmd.clear_coords = 1'b1;
          cmd.set_bad      = 1'b1;
          started_nxt      = 1'b0;
          state_nxt        = S_DONE;
        end else if (restart_r || !started_r) begin
          cmd.clear_coords = 1'b1;
          cmd.stride_init  = 1'b1;
          started_nxt      = 1'b1;
          if (ND > 1) begin
            dim_nxt   = DW'(1);
            state_nxt = S_STRIDE;
          end else begin
            dim_nxt   = '0;
            state_nxt = (n_dims == '0) ? S_DONE : S_POS;
          end
        end else begin
          cmd.advance = 1'b1;
          dim_nxt     = '0;
          state_nxt   = (n_dims == '0) ? S_DONE : S_POS;
        end
      end
      S_STRIDE: begin
        cmd.stride_step = 1'b1;
        if (32'(dim_r) == ND - 1) begin
          dim_nxt   = '0;
          state_nxt = (n_dims == '0) ? S_DONE : S_POS;
        end else begin
          dim_nxt = dim_r + DW'(1);
        end
      end
      S_POS: begin
        cmd.pos_load = 1'b1;
        state_nxt    = S_MAC;
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        if (NW'(dim_r) + NW'(1) == n_dims) begin
          state_nxt = S_DONE;
        end else begin
          dim_nxt   = dim_r + DW'(1);
          state_nxt = S_POS;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_wr_en) begin
      dirty_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dim_r       <= '0;
      step_r      <= '0;
      dirty_r     <= 1'b1;
      started_r   <= 1'b0;
      restart_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dim_r       <= dim_nxt;
      step_r      <= step_nxt;
      dirty_r     <= dirty_nxt;
      started_r   <= started_nxt;
      restart_r   <= restart_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_div_only_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_STEP) |-> dirty_r)
    else $error("divider running with clean shape data");

  a_mac_dim_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (NW'(dim_r) < n_dims))
    else $error("index accumulate beyond dimensions in use");

  a_bad_drops_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && !sts.shape_ok) |=> (state_r == S_DONE && !started_r))
    else $error("bad shape did not go straight to result");

  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished result not loaded");
`endif

endmodule

### design/bsig_dpath.sv
module bsig_dpath #(
  parameter int MAX_DIMS   = bsig_pkg::DEF_MAX_DIMS,
  parameter int MAX_EXTENT = bsig_pkg::DEF_MAX_EXTENT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [bsig_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bsig_pkg::EXT_W-1:0]        cfg_wr_data,
  input  bsig_pkg::cmd_t                    cmd,
  input  logic [((((MAX_DIMS < bsig_pkg::NUM_REGS) ? MAX_DIMS
                  : bsig_pkg::NUM_REGS) > 1) ? $clog2((MAX_DIMS < bsig_pkg::NUM_REGS)
                  ? MAX_DIMS : bsig_pkg::NUM_REGS) : 1)-1:0] dim,
  output bsig_pkg::sts_t                    sts,
  output logic [$clog2(((MAX_DIMS < bsig_pkg::NUM_REGS) ? MAX_DIMS
                        : bsig_pkg::NUM_REGS) + 1)-1:0] n_dims,
  output logic [bsig_pkg::IDX_W-1:0]        out_tdata,
  output logic                              out_tlast,
  output logic                              out_tuser
);
  import bsig_pkg::*;

  localparam int ND   = (MAX_DIMS < NUM_REGS) ? MAX_DIMS : NUM_REGS;
  localparam int NW   = $clog2(ND + 1);
  localparam int DW   = (ND > 1) ? $clog2(ND) : 1;
  localparam int CW   = $clog2(MAX_EXTENT);
  localparam int CMPW = ((CW > EXT_W) ? CW : EXT_W) + 1;
  localparam int PW   = CW + EXT_W;
  localparam int SPW  = IDX_W + EXT_W;
  localparam int MPW  = PW + IDX_W;

  logic [NUMD_W-1:0] num_dims_r;
  logic [EXT_W-1:0]  extent_r [ND];
  logic [EXT_W-1:0]  tile_r   [ND];

  logic [EXT_W-1:0]  ntiles_r [ND];
  logic [ND-1:0]     bad_r;
  logic [EXT_W-1:0]  rem_r, dvd_r, quo_r;
  logic [CW-1:0]     inner_r  [ND];
  logic [CW-1:0]     tcoord_r [ND];
  logic [IDX_W-1:0]  stride_r [ND];
  logic [PW-1:0]     pos_r;
  logic [IDX_W-1:0]  acc_r;
  logic              res_bad_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_last_r, out_bad_r;

  logic [EXT_W:0]    div_shift, div_diff;
  logic              div_ge;
  logic [DW-1:0]     prev_dim;
  logic [EXT_W-1:0]  ext_sel;
  logic [SPW-1:0]    str_prod;
  logic [MPW-1:0]    mac_prod;
  logic [CMPW-1:0]   inc_i [ND];
  logic [CMPW-1:0]   inc_t [ND];
  logic [ND-1:0]     wrap_i, wrap_t, upd_i, upd_t;
  logic              carry, last_all, shape_ok;

  always_comb begin
    if (32'(num_dims_r) > ND) begin
      n_dims = NW'(ND);
    end else begin
      n_dims = NW'(num_dims_r);
    end
  end

  assign div_shift = {rem_r, dvd_r[EXT_W-1]};
  assign div_diff  = div_shift - {1'b0, tile_r[dim]};
  assign div_ge    = (div_shift >= {1'b0, tile_r[dim]});

  assign prev_dim = dim - DW'(1);
  assign ext_sel  = (int'(prev_dim) < int'(n_dims)) ? extent_r[prev_dim] : EXT_W'(1);
  assign str_prod = SPW'(stride_r[prev_dim]) * SPW'(ext_sel);
  assign mac_prod = MPW'(pos_r) * MPW'(stride_r[dim]);

  always_comb begin
    carry    = 1'b1;
    last_all = 1'b1;
    shape_ok = 1'b1;
    for (int d = 0; d < ND; d++) begin
      inc_i[d]  = CMPW'(inner_r[d]) + CMPW'(1);
      inc_t[d]  = CMPW'(tcoord_r[d]) + CMPW'(1);
      wrap_i[d] = (inc_i[d] >= CMPW'(tile_r[d]));
      wrap_t[d] = (inc_t[d] >= CMPW'(ntiles_r[d]));
      upd_i[d]  = 1'b0;
      upd_t[d]  = 1'b0;
    end
    for (int d = 0; d < ND; d++) begin
      if (d < int'(n_dims)) begin
        upd_i[d] = carry;
        carry    = carry && wrap_i[d];
        if (bad_r[d]) begin
          shape_ok = 1'b0;
        end
        if (inc_i[d] != CMPW'(tile_r[d]) || inc_t[d] != CMPW'(ntiles_r[d])) begin
          last_all = 1'b0;
        end
      end
    end
    for (int d = 0; d < ND; d++) begin
      if (d < int'(n_dims)) begin
        upd_t[d] = carry;
        carry    = carry && wrap_t[d];
      end
    end
  end

  assign sts.shape_ok = shape_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= NUMD_W'(1);
      for (int d = 0; d < ND; d++) begin
        extent_r[d] <= EXT_W'(1);
        tile_r[d]   <= EXT_W'(1);
      end
    end else if (cfg_wr_en) begin
      if (cfg_addr == CFG_NUM_DIMS) begin
        num_dims_r <= cfg_wr_data[NUMD_W-1:0];
      end
      for (int d = 0; d < ND; d++) begin
        if (32'(cfg_addr) == 32'(CFG_EXTENT_0) + d) begin
          extent_r[d] <= cfg_wr_data;
        end
        if (32'(cfg_addr) == 32'(CFG_TILE_0) + d) begin
          tile_r[d] <= cfg_wr_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= '0;
      dvd_r <= extent_r[dim];
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? div_diff[EXT_W-1:0] : div_shift[EXT_W-1:0];
      dvd_r <= {dvd_r[EXT_W-2:0], 1'b0};
      quo_r <= {quo_r[EXT_W-2:0], div_ge};
    end
    if (cmd.div_store) begin
      ntiles_r[dim] <= quo_r;
      bad_r[dim]    <= (extent_r[dim] == '0) || (32'(extent_r[dim]) > MAX_EXTENT) ||
                       (tile_r[dim] == '0) || (rem_r != '0);
    end

    if (cmd.clear_coords) begin
      for (int d = 0; d < ND; d++) begin
        inner_r[d]  <= '0;
        tcoord_r[d] <= '0;
      end
    end else if (cmd.advance) begin
      for (int d = 0; d < ND; d++) begin
        if (upd_i[d]) begin
          inner_r[d] <= wrap_i[d] ? '0 : inc_i[d][CW-1:0];
        end
        if (upd_t[d]) begin
          tcoord_r[d] <= wrap_t[d] ? '0 : inc_t[d][CW-1:0];
        end
      end
    end

    if (cmd.stride_init) begin
      stride_r[0] <= IDX_W'(1);
    end
    if (cmd.stride_step) begin
      stride_r[dim] <= str_prod[IDX_W-1:0];
    end

    if (cmd.acc_clear) begin
      acc_r     <= '0;
      res_bad_r <= cmd.set_bad;
    end
    if (cmd.pos_load) begin
      pos_r <= PW'(tcoord_r[dim]) * PW'(tile_r[dim]) + PW'(inner_r[dim]);
    end
    if (cmd.mac) begin
      acc_r <= acc_r + mac_prod[IDX_W-1:0];
    end

    if (cmd.out_load) begin
      out_idx_r  <= res_bad_r ? '0 : acc_r;
      out_last_r <= !res_bad_r && last_all;
      out_bad_r  <= res_bad_r;
    end
  end

  assign out_tdata = out_idx_r;
  assign out_tlast = out_last_r;
  assign out_tuser = out_bad_r;

endmodule

### design/blocked_scan_index_generator_core.sv
// Channel | Bus                         | Contents
// in      | in_tvalid/in_tready/in_tdata| tdata[0] restart
// out     | out_tvalid/out_tready/...   | tdata[23:0] elem_index, tlast last_of_run,
//         |                             | tuser[0] bad_shape
// cfg     | cfg_wr_en/cfg_addr/...      | register index, 9-bit write data
//
// A transfer runs the shape check, a position load and accumulate per dimension in use,
// then loads the result; input ready returns with result valid. A bad shape skips the sum.
// A restart adds a stride pass; a config write makes the next item run the shared divider.
// Index is summed one dimension at a time; synchronous active-low reset, no clearing pass.
// A held result lets one more transfer in; that item then waits until the output frees.
module blocked_scan_index_generator_core #(
  parameter int MAX_DIMS   = bsig_pkg::DEF_MAX_DIMS,
  parameter int MAX_EXTENT = bsig_pkg::DEF_MAX_EXTENT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bsig_pkg::IN_TDATA_W-1:0]  in_tdata,    // [0] restart
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bsig_pkg::IDX_W-1:0]       out_tdata,   // [23:0] elem_index
  output logic                             out_tlast,
  output logic                             out_tuser,   // [0] bad_shape
  input  logic                             cfg_wr_en,
  input  logic [bsig_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bsig_pkg::EXT_W-1:0]       cfg_wr_data
);
  import bsig_pkg::*;

  localparam int ND = (MAX_DIMS < NUM_REGS) ? MAX_DIMS : NUM_REGS;
  localparam int NW = $clog2(ND + 1);
  localparam int DW = (ND > 1) ? $clog2(ND) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [NW-1:0] n_dims;
  logic [DW-1:0] dim;

  bsig_ctrl #(
    .MAX_DIMS (MAX_DIMS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_restart (in_tdata[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .sts        (sts),
    .n_dims     (n_dims),
    .cmd        (cmd),
    .dim        (dim)
  );

  bsig_dpath #(
    .MAX_DIMS   (MAX_DIMS),
    .MAX_EXTENT (MAX_EXTENT)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .dim         (dim),
    .sts         (sts),
    .n_dims      (n_dims),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule
